// ===== hdl/terrain_agl_tracker_macros.svh =====
// Assertion macros shared by the terrain AGL tracker RTL.
// Stand-alone header; each macro takes its clock and synchronous reset.
`ifndef TERRAIN_AGL_TRACKER_MACROS_SVH
`define TERRAIN_AGL_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TAT_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TAT_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== hdl/tat_pkg.sv =====
// Shared types and constants for the terrain AGL tracker.
// No dependencies; imported by every tracker module.
`default_nettype none

package tat_pkg;

   localparam int TIME_W      = 32;
   localparam int POS_W       = 32;
   localparam int ALT_W       = 25;
   localparam int TERR_W      = 21;
   localparam int AGE_W       = 16;
   localparam int CMD_W       = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 32;

   localparam logic [AGE_W-1:0] GPS_MAX_AGE_RST = 16'd3000;
   localparam logic [AGE_W-1:0] ARM_WINDOW_RST  = 16'd2000;

   typedef enum logic [CMD_W-1:0] {
      CMD_ARM   = 2'd0,
      CMD_GPS   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GPS_MAX_AGE = 1'b0,
      CSR_ARM_WINDOW  = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type                    command;
      logic [TIME_W-1:0]          now_ms;
      logic                       arm_state;
      logic                       fix_ok;
      logic signed [POS_W-1:0]    latitude_e7;
      logic signed [POS_W-1:0]    longitude_e7;
      logic signed [ALT_W-1:0]    gps_altitude_cm;
      logic                       terrain_found;
      logic signed [TERR_W-1:0]   terrain_elevation_cm;
   } item_type;

   typedef struct packed {
      logic                       agl_good;
      logic signed [ALT_W-1:0]    agl_cm;
      logic                       is_calibrated;
      logic                       calibration_waiting;
      logic                       just_calibrated;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/tat_ingress.sv =====
// Input stage of the terrain AGL tracker: unpacks and registers one request.
// Depends on tat_pkg.
`default_nettype none

module tat_ingress (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: now_ms, arm_state, fix_ok, latitude_e7, longitude_e7,
   //        gps_altitude_cm, terrain_found, terrain_elevation_cm, zero pad
   input  wire logic [tat_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: command
   input  wire logic [tat_pkg::CMD_W-1:0]        req_tuser,
   input  wire logic                             advance,
   output logic                                  item_valid,
   output tat_pkg::item_type                     item
);
   import tat_pkg::*;

   logic     valid_ff;
   item_type item_ff;
   item_type item_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      item_in.command              = cmd_type'(req_tuser);
      item_in.now_ms               = req_tdata[31:0];
      item_in.arm_state            = req_tdata[32];
      item_in.fix_ok               = req_tdata[33];
      item_in.latitude_e7          = req_tdata[65:34];
      item_in.longitude_e7         = req_tdata[97:66];
      item_in.gps_altitude_cm      = req_tdata[122:98];
      item_in.terrain_found        = req_tdata[123];
      item_in.terrain_elevation_cm = req_tdata[144:124];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hdl/tat_core.sv =====
// Tracker state, settings registers and per-item update logic.
// Depends on tat_pkg and terrain_agl_tracker_macros.svh.
`default_nettype none

module tat_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wen,
   input  wire logic [tat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tat_pkg::AGE_W-1:0]       csr_wdata,
   input  wire logic                            fire,
   input  wire tat_pkg::item_type               item,
   output tat_pkg::result_type                  result
);
   import tat_pkg::*;

   `include "terrain_agl_tracker_macros.svh"

   localparam logic signed [POS_W-1:0] LAT_MAX = 32'sd900000000;
   localparam logic signed [POS_W-1:0] LON_MAX = 32'sd1800000000;
   localparam int AGL_RAW_W = ALT_W + 2;
   localparam logic signed [AGL_RAW_W-1:0] AGL_MAX = 27'sd12100000;
   localparam logic signed [AGL_RAW_W-1:0] AGL_MIN = -27'sd12100000;
   localparam logic signed [ALT_W-1:0] OFF_MAX = {1'b0, {(ALT_W-1){1'b1}}};
   localparam logic signed [ALT_W-1:0] OFF_MIN = {1'b1, {(ALT_W-1){1'b0}}};

   function automatic logic fresh(input logic [TIME_W-1:0] t,
                                  input logic [TIME_W-1:0] now,
                                  input logic [AGE_W-1:0]  max_age);
      logic [TIME_W-1:0] age;
      age = now - t;
      return (now >= t) && (age <= {{(TIME_W-AGE_W){1'b0}}, max_age});
   endfunction

   logic [AGE_W-1:0] gps_max_age_ff, arm_window_ff;

   logic seen_disarm_ff, armed_ff, pending_ff, calibrated_ff, gps_ok_ff, agl_ok_ff;
   logic seen_disarm_in, armed_in, pending_in, calibrated_in, gps_ok_in, agl_ok_in;
   logic signed [ALT_W-1:0] last_alt_ff, home_offset_ff, current_agl_ff;
   logic signed [ALT_W-1:0] last_alt_in, home_offset_in, current_agl_in;
   logic [TIME_W-1:0] arm_time_ff, last_gps_time_ff, arm_time_in, last_gps_time_in;

   logic                    pos_ok;
   logic                    arm_fresh;
   logic                    gps_fresh;
   logic signed [ALT_W-1:0] alt_sel;
   logic signed [ALT_W:0]   off_raw;
   logic signed [ALT_W-1:0] off_sat;
   logic signed [AGL_RAW_W-1:0] agl_raw;
   logic signed [ALT_W-1:0] agl_sat;
   logic                    just;
   logic                    cal_done;
   logic                    valid;

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gps_max_age_ff <= GPS_MAX_AGE_RST;
         arm_window_ff  <= ARM_WINDOW_RST;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_GPS_MAX_AGE: gps_max_age_ff <= csr_wdata;
            CSR_ARM_WINDOW:  arm_window_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_ok = item.fix_ok &&
               item.latitude_e7 >= -LAT_MAX && item.latitude_e7 <= LAT_MAX &&
               item.longitude_e7 >= -LON_MAX && item.longitude_e7 <= LON_MAX;
      arm_fresh = fresh(arm_time_ff, item.now_ms, arm_window_ff);
      gps_fresh = fresh(last_gps_time_ff, item.now_ms, gps_max_age_ff);

      // Arm events calibrate against the stored altitude, GPS against its own
      alt_sel = (item.command == CMD_ARM) ? last_alt_ff : item.gps_altitude_cm;
      off_raw = {alt_sel[ALT_W-1], alt_sel}
                - {{(ALT_W+1-TERR_W){item.terrain_elevation_cm[TERR_W-1]}},
                   item.terrain_elevation_cm};
      if (off_raw[ALT_W] != off_raw[ALT_W-1]) begin
         off_sat = off_raw[ALT_W] ? OFF_MIN : OFF_MAX;
      end else begin
         off_sat = off_raw[ALT_W-1:0];
      end

      agl_raw = {{2{item.gps_altitude_cm[ALT_W-1]}}, item.gps_altitude_cm}
                - {{(AGL_RAW_W-TERR_W){item.terrain_elevation_cm[TERR_W-1]}},
                   item.terrain_elevation_cm}
                - (calibrated_ff ? {{2{home_offset_ff[ALT_W-1]}}, home_offset_ff}
                                 : AGL_RAW_W'(0));
      if (agl_raw > AGL_MAX) begin
         agl_sat = AGL_MAX[ALT_W-1:0];
      end else if (agl_raw < AGL_MIN) begin
         agl_sat = AGL_MIN[ALT_W-1:0];
      end else begin
         agl_sat = agl_raw[ALT_W-1:0];
      end
   end

   always_comb begin
      seen_disarm_in   = seen_disarm_ff;
      armed_in         = armed_ff;
      pending_in       = pending_ff;
      calibrated_in    = calibrated_ff;
      gps_ok_in        = gps_ok_ff;
      agl_ok_in        = agl_ok_ff;
      last_alt_in      = last_alt_ff;
      home_offset_in   = home_offset_ff;
      current_agl_in   = current_agl_ff;
      arm_time_in      = arm_time_ff;
      last_gps_time_in = last_gps_time_ff;
      just             = 1'b0;
      cal_done         = 1'b0;

      unique case (item.command)
         CMD_ARM: begin
            if (!item.arm_state) begin
               seen_disarm_in = 1'b1;
               armed_in       = 1'b0;
               pending_in     = 1'b0;
            end else if (!armed_ff) begin
               armed_in    = 1'b1;
               arm_time_in = item.now_ms;
               pending_in  = seen_disarm_ff;
               // Window opens now, so only GPS status, GPS age and terrain gate capture
               if (seen_disarm_ff && gps_ok_ff && gps_fresh) begin
                  pending_in = 1'b0;
                  if (item.terrain_found) begin
                     home_offset_in = off_sat;
                     current_agl_in = '0;
                     calibrated_in  = 1'b1;
                     agl_ok_in      = 1'b1;
                     just           = 1'b1;
                  end
               end
            end
         end
         CMD_GPS: begin
            if (!pos_ok) begin
               gps_ok_in = 1'b0;
               agl_ok_in = 1'b0;
            end else begin
               last_alt_in      = item.gps_altitude_cm;
               last_gps_time_in = item.now_ms;
               gps_ok_in        = 1'b1;
               if (pending_ff && armed_ff) begin
                  pending_in = 1'b0;
                  if (arm_fresh && item.terrain_found) begin
                     home_offset_in = off_sat;
                     current_agl_in = '0;
                     calibrated_in  = 1'b1;
                     agl_ok_in      = 1'b1;
                     just           = 1'b1;
                     cal_done       = 1'b1;
                  end
               end
               if (!cal_done) begin
                  if (!item.terrain_found) begin
                     agl_ok_in = 1'b0;
                  end else begin
                     current_agl_in = agl_sat;
                     agl_ok_in      = 1'b1;
                  end
               end
            end
         end
         CMD_QUERY: ;
         CMD_CLEAR: begin
            seen_disarm_in   = 1'b0;
            armed_in         = 1'b0;
            pending_in       = 1'b0;
            calibrated_in    = 1'b0;
            gps_ok_in        = 1'b0;
            agl_ok_in        = 1'b0;
            last_alt_in      = '0;
            home_offset_in   = '0;
            current_agl_in   = '0;
            arm_time_in      = '0;
            last_gps_time_in = '0;
         end
         default: ;
      endcase

      valid = gps_ok_in && agl_ok_in &&
              fresh(last_gps_time_in, item.now_ms, gps_max_age_ff);

      result.agl_good            = valid;
      result.agl_cm              = valid ? current_agl_in : '0;
      result.is_calibrated       = calibrated_in;
      result.calibration_waiting = pending_in;
      result.just_calibrated     = just;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_disarm_ff   <= 1'b0;
         armed_ff         <= 1'b0;
         pending_ff       <= 1'b0;
         calibrated_ff    <= 1'b0;
         gps_ok_ff        <= 1'b0;
         agl_ok_ff        <= 1'b0;
         last_alt_ff      <= '0;
         home_offset_ff   <= '0;
         current_agl_ff   <= '0;
         arm_time_ff      <= '0;
         last_gps_time_ff <= '0;
      end else if (fire) begin
         seen_disarm_ff   <= seen_disarm_in;
         armed_ff         <= armed_in;
         pending_ff       <= pending_in;
         calibrated_ff    <= calibrated_in;
         gps_ok_ff        <= gps_ok_in;
         agl_ok_ff        <= agl_ok_in;
         last_alt_ff      <= last_alt_in;
         home_offset_ff   <= home_offset_in;
         current_agl_ff   <= current_agl_in;
         arm_time_ff      <= arm_time_in;
         last_gps_time_ff <= last_gps_time_in;
      end
   end

   `TAT_ASSERT_NOW(a_just_cal_flags, clock, reset, fire && result.just_calibrated, result.is_calibrated && !result.calibration_waiting, "capture left flags inconsistent")
   `TAT_ASSERT_NEXT(a_clear_state, clock, reset, fire && item.command == CMD_CLEAR, !calibrated_ff && !pending_ff && !gps_ok_ff && !armed_ff, "clear did not reset state")
   `TAT_ASSERT_NEXT(a_valid_state, clock, reset, fire && result.agl_good, gps_ok_ff && agl_ok_ff, "valid AGL without stored GPS and AGL status")
   `TAT_ASSERT_NEXT(a_offset_hold, clock, reset, !fire, $stable(home_offset_ff) && $stable(calibrated_ff), "state moved without a transfer")

endmodule

`default_nettype wire

// ===== hdl/terrain_agl_tracker.sv =====
// Terrain AGL tracker top level: input register, state update, result register.
// A request is registered in tat_ingress, then its result in the result register.
// Throughput: one item per cycle while rsp_tready does not stall the result register.
// Reset: synchronous, active high; clears all tracker state and both channels,
// and loads gps_max_age_ms = 3000 and arm_window_ms = 2000.
// Depends on tat_pkg, tat_ingress and tat_core.
`default_nettype none

module terrain_agl_tracker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: now_ms, arm_state, fix_ok, latitude_e7, longitude_e7,
   //        gps_altitude_cm, terrain_found, terrain_elevation_cm, zero pad
   input  wire logic [tat_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: command
   input  wire logic [tat_pkg::CMD_W-1:0]        req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: agl_good, agl_cm, is_calibrated, calibration_waiting,
   //        just_calibrated, zero pad
   output logic [tat_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_wen,
   input  wire logic [tat_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tat_pkg::AGE_W-1:0]        csr_wdata
);
   import tat_pkg::*;

   logic       advance;
   logic       item_valid;
   logic       fire;
   item_type   item;
   result_type result;

   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   // Move the staged item forward whenever the result slot is free or drains
   assign advance = !rsp_valid_ff || rsp_tready;
   assign fire    = item_valid && advance;

   tat_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   tat_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (item),
      .result    (result)
   );

   assign rsp_data_in = {3'b000,
                         result.just_calibrated,
                         result.calibration_waiting,
                         result.is_calibrated,
                         result.agl_cm,
                         result.agl_good};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== dv/terrain_agl_tracker_checker.sv =====
// Checker for the terrain AGL tracker: watches the request, result and CSR
// channels, predicts every result and compares it field by field.
// Depends on tat_pkg; hands its failure count to the testbench top.

module terrain_agl_tracker_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [tat_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [tat_pkg::CMD_W-1:0]       req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tat_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_wen,
   input  logic [tat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tat_pkg::AGE_W-1:0]       csr_wdata,
   output int                              fail_total,
   output int                              reports_left
);
   import tat_pkg::*;

   localparam longint AGL_LIMIT  = 12100000;
   localparam longint OFFSET_MAX = 16777215;
   localparam longint OFFSET_MIN = -16777216;

   // tracker state as the block should hold it
   logic                     seen_disarm, armed, calib_pending, calibrated;
   logic                     gps_ok, agl_ok;
   logic signed [ALT_W-1:0]  gps_alt, home_offset;
   logic signed [ALT_W:0]    cur_agl;
   logic [TIME_W-1:0]        arm_stamp, gps_stamp;
   logic [AGE_W-1:0]         gps_max_age, arm_window;

   result_type agl_reports_due [$];
   int failures = 0;

   function automatic longint saturate(longint x, longint lo, longint hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // an earlier time than the stamp counts as stale
   function automatic logic is_fresh(logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] now,
                                     logic [AGE_W-1:0] max_age);
      return (now >= stamp) && ((now - stamp) <= {16'd0, max_age});
   endfunction

   function automatic void clear_tracker();
      seen_disarm   = 1'b0;
      armed         = 1'b0;
      calib_pending = 1'b0;
      calibrated    = 1'b0;
      gps_ok        = 1'b0;
      agl_ok        = 1'b0;
      gps_alt       = '0;
      home_offset   = '0;
      cur_agl       = '0;
      arm_stamp     = '0;
      gps_stamp     = '0;
   endfunction

   function automatic logic capture_home(logic [TIME_W-1:0] now, logic found, longint terr);
      if (!armed || !calib_pending || !gps_ok) return 1'b0;
      if (!is_fresh(arm_stamp, now, arm_window)) begin
         calib_pending = 1'b0;
         return 1'b0;
      end
      if (!is_fresh(gps_stamp, now, gps_max_age)) return 1'b0;
      // no terrain under the home position: give up on this window
      if (!found) begin
         calib_pending = 1'b0;
         return 1'b0;
      end
      home_offset   = saturate(longint'(gps_alt) - terr, OFFSET_MIN, OFFSET_MAX);
      cur_agl       = '0;
      calib_pending = 1'b0;
      calibrated    = 1'b1;
      agl_ok        = 1'b1;
      return 1'b1;
   endfunction

   function automatic result_type track_item(item_type it);
      result_type rep;
      logic       captured;
      logic       geo_ok;
      longint     lat, lon, alt, terr, height;
      captured = 1'b0;
      lat  = longint'($signed(it.latitude_e7));
      lon  = longint'($signed(it.longitude_e7));
      alt  = longint'($signed(it.gps_altitude_cm));
      terr = longint'($signed(it.terrain_elevation_cm));
      case (it.command)
         CMD_ARM: begin
            if (!it.arm_state) begin
               seen_disarm   = 1'b1;
               armed         = 1'b0;
               calib_pending = 1'b0;
            end else if (!armed) begin
               armed         = 1'b1;
               arm_stamp     = it.now_ms;
               calib_pending = seen_disarm;
               captured      = capture_home(it.now_ms, it.terrain_found, terr);
            end
         end
         CMD_GPS: begin
            geo_ok = it.fix_ok && lat >= -900000000 && lat <= 900000000 &&
                     lon >= -1800000000 && lon <= 1800000000;
            if (!geo_ok) begin
               gps_ok = 1'b0;
               agl_ok = 1'b0;
            end else begin
               gps_alt   = it.gps_altitude_cm;
               gps_stamp = it.now_ms;
               gps_ok    = 1'b1;
               if (calib_pending && capture_home(it.now_ms, it.terrain_found, terr)) begin
                  captured = 1'b1;
               end else if (!it.terrain_found) begin
                  agl_ok = 1'b0;
               end else begin
                  height = alt - terr;
                  if (calibrated) height -= longint'(home_offset);
                  cur_agl = saturate(height, -AGL_LIMIT, AGL_LIMIT);
                  agl_ok  = 1'b1;
               end
            end
         end
         CMD_CLEAR: clear_tracker();
         default: ;
      endcase
      rep.agl_good            = gps_ok && agl_ok && is_fresh(gps_stamp, it.now_ms, gps_max_age);
      rep.agl_cm              = rep.agl_good ? cur_agl[ALT_W-1:0] : '0;
      rep.is_calibrated       = calibrated;
      rep.calibration_waiting = calib_pending;
      rep.just_calibrated     = captured;
      return rep;
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      item_type   it;
      result_type want, got;
      if (reset) begin
         clear_tracker();
         gps_max_age = GPS_MAX_AGE_RST;
         arm_window  = ARM_WINDOW_RST;
         agl_reports_due.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_GPS_MAX_AGE: gps_max_age = csr_wdata;
               CSR_ARM_WINDOW:  arm_window  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.agl_good            = rsp_tdata[0];
            got.agl_cm              = rsp_tdata[ALT_W:1];
            got.is_calibrated       = rsp_tdata[ALT_W+1];
            got.calibration_waiting = rsp_tdata[ALT_W+2];
            got.just_calibrated     = rsp_tdata[ALT_W+3];
            if (agl_reports_due.size() == 0) begin
               $error("result transfer with no result expected: tdata %h", rsp_tdata);
               failures++;
            end else begin
               want = agl_reports_due.pop_front();
               check_field("agl_good", want.agl_good, got.agl_good);
               check_field("agl_cm", $signed(want.agl_cm), $signed(got.agl_cm));
               check_field("is_calibrated", want.is_calibrated, got.is_calibrated);
               check_field("calibration_waiting", want.calibration_waiting,
                           got.calibration_waiting);
               check_field("just_calibrated", want.just_calibrated, got.just_calibrated);
            end
         end
         if (req_tvalid && req_tready) begin
            // tdata from bit 0: now_ms, arm state, fix flag, latitude, longitude,
            // altitude, terrain_found, terrain elevation
            it.command              = cmd_type'(req_tuser);
            it.now_ms               = req_tdata[31:0];
            it.arm_state            = req_tdata[32];
            it.fix_ok               = req_tdata[33];
            it.latitude_e7          = req_tdata[65:34];
            it.longitude_e7         = req_tdata[97:66];
            it.gps_altitude_cm      = req_tdata[122:98];
            it.terrain_found        = req_tdata[123];
            it.terrain_elevation_cm = req_tdata[144:124];
            agl_reports_due.push_back(track_item(it));
         end
      end
      fail_total   <= failures;
      reports_left <= agl_reports_due.size();
   end

endmodule

// ===== dv/terrain_agl_tracker_test.sv =====
// Testbench top for terrain_agl_tracker: clock, reset, directed and random
// arm/GPS/query/clear traffic, CSR phases and the verdict.
// Depends on tat_pkg, the tracker RTL and terrain_agl_tracker_checker.

module terrain_agl_tracker_test;
   import tat_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 6;
   localparam int RSP_HOLD_CYCLES = 120;
   localparam int PHASE_ITEMS     = 155;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic [CMD_W-1:0]         req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index  = '0;
   logic [AGE_W-1:0]         csr_wdata  = '0;

   int fail_total;
   int reports_left;
   int items_sent = 0;
   int idle_cycles = 0;

   bit sender_bursty = 1'b0;
   bit rsp_bursty    = 1'b0;
   bit rsp_hold_req  = 1'b0;

   logic [TIME_W-1:0] sim_ms = '0;

   always #10 clock = ~clock;

   terrain_agl_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   terrain_agl_tracker_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .fail_total   (fail_total),
      .reports_left (reports_left)
   );

   // ---------------------------------------------------------------- items

   function automatic logic [TIME_W-1:0] next_stamp();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         // same millisecond
      end else if (pick < 60) begin
         sim_ms += $urandom_range(1, 400);
      end else if (pick < 85) begin
         sim_ms += $urandom_range(400, 4000);
      end else if (pick < 93) begin
         sim_ms += $urandom_range(4000, 70000);
      end else if (pick < 97) begin
         sim_ms -= $urandom_range(1, 5000);
      end else begin
         sim_ms = $urandom;
      end
      return sim_ms;
   endfunction

   function automatic logic signed [POS_W-1:0] draw_lat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return $urandom_range(0, 1800000000) - 900000000;
      if (pick < 93) return $urandom_range(0, 1) ? 32'sd900000001 : -32'sd900000001;
      return $urandom;
   endfunction

   function automatic logic signed [POS_W-1:0] draw_lon();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 85) return $urandom_range(0, 32'd3600000000) - 32'd1800000000;
      if (pick < 93) return $urandom_range(0, 1) ? 32'sd1800000001 : -32'sd1800000001;
      return $urandom;
   endfunction

   function automatic logic signed [ALT_W-1:0] draw_alt();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 4) != 0) return ALT_W'($urandom_range(0, 11000000) - 1000000);
      return r[ALT_W-1:0];
   endfunction

   function automatic logic signed [TERR_W-1:0] draw_terrain();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 4) != 0) return TERR_W'($urandom_range(0, 1100000) - 100000);
      return r[TERR_W-1:0];
   endfunction

   // every field random; builders below overwrite what a command uses
   function automatic item_type noise_item();
      item_type    it;
      logic [31:0] r;
      it.command              = cmd_type'($urandom_range(0, 3));
      it.now_ms               = $urandom;
      it.arm_state            = 1'($urandom_range(0, 1));
      it.fix_ok               = 1'($urandom_range(0, 1));
      it.latitude_e7          = $urandom;
      it.longitude_e7         = $urandom;
      r = $urandom;
      it.gps_altitude_cm      = r[ALT_W-1:0];
      it.terrain_found        = 1'($urandom_range(0, 1));
      r = $urandom;
      it.terrain_elevation_cm = r[TERR_W-1:0];
      return it;
   endfunction

   function automatic item_type plain_item(cmd_type cmd, logic [TIME_W-1:0] stamp);
      item_type it;
      it         = noise_item();
      it.command = cmd;
      it.now_ms  = stamp;
      return it;
   endfunction

   function automatic item_type arm_item(logic [TIME_W-1:0] stamp, logic arm_state,
                                         logic found, logic signed [TERR_W-1:0] terr);
      item_type it;
      it                      = plain_item(CMD_ARM, stamp);
      it.arm_state            = arm_state;
      it.terrain_found        = found;
      it.terrain_elevation_cm = terr;
      return it;
   endfunction

   function automatic item_type gps_item(logic [TIME_W-1:0] stamp, logic fix,
                                         logic signed [POS_W-1:0] lat,
                                         logic signed [POS_W-1:0] lon,
                                         logic signed [ALT_W-1:0] alt, logic found,
                                         logic signed [TERR_W-1:0] terr);
      item_type it;
      it                      = plain_item(CMD_GPS, stamp);
      it.fix_ok               = fix;
      it.latitude_e7          = lat;
      it.longitude_e7         = lon;
      it.gps_altitude_cm      = alt;
      it.terrain_found        = found;
      it.terrain_elevation_cm = terr;
      return it;
   endfunction

   function automatic item_type gps_random();
      return gps_item(next_stamp(), $urandom_range(0, 9) != 0, draw_lat(), draw_lon(),
                      draw_alt(), $urandom_range(0, 6) != 0, draw_terrain());
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_item(item_type it);
      int                     gap;
      logic [REQ_TDATA_W-1:0] payload;
      gap = sender_bursty ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      payload = '0;
      payload[144:0] = {it.terrain_elevation_cm, it.terrain_found, it.gps_altitude_cm,
                        it.longitude_e7, it.latitude_e7, it.fix_ok, it.arm_state,
                        it.now_ms};
      req_tvalid <= 1'b1;
      req_tdata  <= payload;
      req_tuser  <= it.command;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_limits(logic [AGE_W-1:0] max_age, logic [AGE_W-1:0] window);
      csr_wen   <= 1'b1;
      csr_index <= CSR_GPS_MAX_AGE;
      csr_wdata <= max_age;
      @(posedge clock);
      csr_index <= CSR_ARM_WINDOW;
      csr_wdata <= window;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // disarm, arm, then a run of mostly GPS samples with some noise mixed in
   task automatic fly_sortie(int steps);
      int pick;
      if ($urandom_range(0, 9) == 0) send_item(plain_item(CMD_CLEAR, next_stamp()));
      send_item(arm_item(next_stamp(), 1'b0, 1'($urandom_range(0, 1)), draw_terrain()));
      repeat ($urandom_range(0, 2)) send_item(gps_random());
      send_item(arm_item(next_stamp(), 1'b1, $urandom_range(0, 9) != 0, draw_terrain()));
      repeat (steps) begin
         pick = $urandom_range(0, 99);
         if (pick < 62)
            send_item(gps_random());
         else if (pick < 77)
            send_item(plain_item(CMD_QUERY, next_stamp()));
         else if (pick < 87)
            send_item(arm_item(next_stamp(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), draw_terrain()));
         else if (pick < 89)
            send_item(plain_item(CMD_CLEAR, next_stamp()));
         else
            send_item(noise_item());
      end
   endtask

   // result side: random stall before each transfer, one long hold-off on request
   initial begin : receiver
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_req = 1'b0;
         end
         stall = rsp_bursty ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("terrain_agl_tracker verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      int target;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset limits of 3000 ms GPS age and 2000 ms arm window
      send_item(plain_item(CMD_QUERY, 32'd0));
      send_item(gps_item(32'd10, 1'b0, 32'sd0, 32'sd0, 25'sd100, 1'b1, 21'sd0));
      send_item(gps_item(32'd20, 1'b1, 32'sd900000001, 32'sd0, 25'sd100, 1'b1, 21'sd0));
      send_item(gps_item(32'd30, 1'b1, 32'sd0, -32'sd1800000001, 25'sd100, 1'b1, 21'sd0));
      send_item(gps_item(32'd40, 1'b1, -32'sd900000000, 32'sd1800000000, 25'sd5000, 1'b1,
                         21'sd1000));
      send_item(gps_item(32'd50, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 25'sd5000, 1'b1,
                         21'sd1000));
      // AGL saturates at both ends
      send_item(gps_item(32'd60, 1'b1, 32'sd900000000, -32'sd1800000000, 25'sd16777215,
                         1'b1, -21'sd1048576));
      send_item(gps_item(32'd70, 1'b1, 32'sd1, 32'sd1, -25'sd16777216, 1'b1,
                         21'sd1048575));
      // arm with no disarm seen, then a window closed by missing terrain
      send_item(arm_item(32'd80, 1'b1, 1'b1, 21'sd0));
      send_item(arm_item(32'd90, 1'b0, 1'b1, 21'sd0));
      send_item(arm_item(32'd100, 1'b1, 1'b0, 21'sd0));
      send_item(arm_item(32'd110, 1'b0, 1'b1, 21'sd0));
      // capture on the arm event, offset saturating low
      send_item(arm_item(32'd120, 1'b1, 1'b1, 21'sd200));
      send_item(gps_item(32'd130, 1'b1, 32'sd1, 32'sd1, 25'sd1000, 1'b1, 21'sd100));
      // age exactly at the limit, one past it, and time going backward
      send_item(plain_item(CMD_QUERY, 32'd3130));
      send_item(plain_item(CMD_QUERY, 32'd3131));
      send_item(plain_item(CMD_QUERY, 32'd100));
      send_item(plain_item(CMD_CLEAR, 32'd3200));
      // arm window expires before the first GPS sample
      send_item(arm_item(32'd3300, 1'b0, 1'b1, 21'sd0));
      send_item(arm_item(32'd3400, 1'b1, 1'b1, 21'sd0));
      send_item(gps_item(32'd5401, 1'b1, 32'sd5, 32'sd5, 25'sd2000, 1'b1, 21'sd500));
      // capture on a GPS sample inside the window
      send_item(arm_item(32'd5500, 1'b0, 1'b1, 21'sd0));
      send_item(gps_item(32'd5550, 1'b0, 32'sd5, 32'sd5, 25'sd2000, 1'b1, 21'sd500));
      send_item(arm_item(32'd5600, 1'b1, 1'b1, 21'sd0));
      send_item(gps_item(32'd6000, 1'b1, 32'sd5, 32'sd5, 25'sd3000, 1'b1, 21'sd700));
      send_item(gps_item(32'hFFFF_FFFF, 1'b1, 32'sd5, 32'sd5, 25'sd9000, 1'b1, 21'sd700));
      wait_drained();

      sim_ms = 32'd7000;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_limits(GPS_MAX_AGE_RST, ARM_WINDOW_RST);
            1: program_limits(16'd0, 16'd0);
            2: program_limits(16'hFFFF, 16'hFFFF);
            3: program_limits(AGE_W'($urandom_range(0, 65535)),
                              AGE_W'($urandom_range(0, 65535)));
            4: program_limits(16'd200, 16'hFFFF);
            default: program_limits(16'hFFFF, 16'd300);
         endcase
         target = items_sent + PHASE_ITEMS;
         // back up the result side once so the input stalls
         if (phase == 2) rsp_hold_req = 1'b1;
         while (items_sent < target) begin
            sender_bursty = ($urandom_range(0, 4) == 0) || rsp_hold_req;
            rsp_bursty    = ($urandom_range(0, 4) == 0);
            fly_sortie($urandom_range(3, 14));
         end
         wait_drained();
      end

      if (fail_total == 0 && reports_left == 0)
         $display("terrain_agl_tracker verification clean");
      else
         $display("terrain_agl_tracker verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tat_pkg.sv
hdl/tat_ingress.sv
hdl/tat_core.sv
hdl/terrain_agl_tracker.sv
dv/terrain_agl_tracker_checker.sv
dv/terrain_agl_tracker_test.sv
